### rtl/trpq_pkg.sv
package trpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TIME_W      = 63;
  localparam int TYPE_W      = 32;
  localparam int REF_W       = 16;
  localparam int OCC_W       = 5;
  localparam int DELAY_W     = 32;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int FIFO_DEPTH  = 2;
  localparam int FPTR_W      = $clog2(FIFO_DEPTH);

  localparam logic KIND_ADD     = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic REG_RELEASE_DELAY = 1'b0;

  typedef struct packed {
    logic              is_rel;
    logic [TIME_W-1:0] stamp;
    logic [TYPE_W-1:0] tag;
    logic [REF_W-1:0]  handle;
  } cmd_t;

endpackage

### rtl/trpq_req_if.sv
interface trpq_req_if import trpq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [TIME_W-1:0] event_time;
  logic [TYPE_W-1:0] event_type;
  logic [REF_W-1:0]  event_handle;
  logic [TIME_W-1:0] now_time;

  modport source (output valid, kind, event_time, event_type, event_handle, now_time,
                  input ready);
  modport sink (input valid, kind, event_time, event_type, event_handle, now_time,
                output ready);
endinterface

### rtl/trpq_rsp_if.sv
interface trpq_rsp_if import trpq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              accepted;
  logic              released;
  logic [TYPE_W-1:0] out_type;
  logic [REF_W-1:0]  out_handle;
  logic [TIME_W-1:0] out_time;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, accepted, released, out_type, out_handle, out_time,
                  occupancy, input ready);
  modport sink (input valid, accepted, released, out_type, out_handle, out_time,
                occupancy, output ready);
endinterface

### rtl/timed_release_priority_queue_core.sv
// Add beat: passes the front stage, the two-entry queue and the back-end result register; one
// add every cycle when the output drains and no release holds the back end. Release beat: the
// back end scans one store slot per cycle, then its finish state writes the result.
// A two-entry queue between front and back lets input beats land during a scan.
// Reset (rst, synchronous): clears slot valid bits, count, queues and release_delay;
// slot contents are not cleared.
module timed_release_priority_queue_core import trpq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  trpq_req_if.sink          req,
  trpq_rsp_if.source        rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [DELAY_W-1:0] release_delay;
  logic               f_valid;
  cmd_t               f_cmd;
  logic               f_ready;
  logic               b_valid;
  cmd_t               b_cmd;
  logic               b_ready;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RELEASE_DELAY) ? release_delay : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      release_delay <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_RELEASE_DELAY)) begin
      release_delay <= pwdata;
    end
  end

  trpq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push_valid (f_valid),
    .push_cmd   (f_cmd),
    .push_ready (f_ready)
  );

  trpq_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_cmd   (f_cmd),
    .push_ready (f_ready),
    .pop_valid  (b_valid),
    .pop_cmd    (b_cmd),
    .pop_ready  (b_ready)
  );

  trpq_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (b_valid),
    .pop_cmd       (b_cmd),
    .pop_ready     (b_ready),
    .release_delay (release_delay),
    .rsp           (rsp)
  );

endmodule

### rtl/trpq_front.sv
module trpq_front import trpq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  trpq_req_if.sink   req,
  output logic       push_valid,
  output cmd_t       push_cmd,
  input  logic       push_ready
);

  logic stage_valid;
  cmd_t stage_cmd;
  cmd_t cmd_next;

  assign req.ready  = !stage_valid || push_ready;
  assign push_valid = stage_valid;
  assign push_cmd   = stage_cmd;

  always_comb begin
    cmd_next.is_rel = (req.kind == KIND_RELEASE);
    cmd_next.stamp  = (req.kind == KIND_RELEASE) ? req.now_time : req.event_time;
    cmd_next.tag    = req.event_type;
    cmd_next.handle = req.event_handle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req.ready) begin
      stage_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      stage_cmd <= cmd_next;
    end
  end

endmodule

### rtl/trpq_fifo.sv
module trpq_fifo import trpq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  cmd_t push_cmd,
  output logic push_ready,
  output logic pop_valid,
  output cmd_t pop_cmd,
  input  logic pop_ready
);

  cmd_t                   slots [FIFO_DEPTH];
  logic [FPTR_W-1:0]      wr_ptr;
  logic [FPTR_W-1:0]      rd_ptr;
  logic [FPTR_W:0]        fill;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready = (fill != (FPTR_W+1)'(FIFO_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

### rtl/trpq_back.sv
module trpq_back import trpq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  input  cmd_t               pop_cmd,
  output logic               pop_ready,
  input  logic [DELAY_W-1:0] release_delay,
  trpq_rsp_if.source         rsp
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]        state;
  logic [TIME_W-1:0] entry_time [QUEUE_DEPTH];
  logic [TYPE_W-1:0] entry_type [QUEUE_DEPTH];
  logic [REF_W-1:0]  entry_ref  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] entry_valid;
  logic [CNT_W-1:0]  count;

  logic [IDX_W-1:0]  scan_idx;
  logic [TIME_W-1:0] now;
  logic              best_found;
  logic [IDX_W-1:0]  best_idx;
  logic [TIME_W-1:0] best_time;
  logic [TYPE_W-1:0] best_type;
  logic [REF_W-1:0]  best_ref;

  logic              res_valid;
  logic              out_free;
  logic              free_any;
  logic [IDX_W-1:0]  free_idx;
  logic              take_scan;
  logic              ripe;
  logic              do_add;
  logic              do_release;

  assign out_free  = !res_valid || rsp.ready;
  assign pop_ready = (state == ST_IDLE) && out_free;
  assign rsp.valid = res_valid;

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign take_scan = entry_valid[scan_idx] &&
                     (!best_found || (entry_time[scan_idx] < best_time) ||
                      ((entry_time[scan_idx] == best_time) &&
                       (entry_ref[scan_idx] < best_ref)));

  assign ripe = best_found &&
                (({1'b0, best_time} + {32'b0, release_delay}) <= {1'b0, now});

  assign do_add     = (state == ST_IDLE) && pop_valid && out_free &&
                      !pop_cmd.is_rel && free_any;
  assign do_release = (state == ST_FINISH) && out_free && ripe;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_valid <= '0;
      count       <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (rsp.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop_valid && out_free) begin
            if (pop_cmd.is_rel) begin
              state <= ST_SCAN;
            end else begin
              res_valid <= 1'b1;
              if (free_any) begin
                entry_valid[free_idx] <= 1'b1;
                count                 <= count + 1'b1;
              end
            end
          end
        end
        ST_SCAN: begin
          if (scan_idx == IDX_W'(QUEUE_DEPTH - 1)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            res_valid <= 1'b1;
            state     <= ST_IDLE;
            if (ripe) begin
              entry_valid[best_idx] <= 1'b0;
              count                 <= count - 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_add) begin
      entry_time[free_idx] <= pop_cmd.stamp;
      entry_type[free_idx] <= pop_cmd.tag;
      entry_ref[free_idx]  <= pop_cmd.handle;
    end
    if (state == ST_IDLE) begin
      scan_idx   <= '0;
      best_found <= 1'b0;
      now        <= pop_cmd.stamp;
    end else if (state == ST_SCAN) begin
      scan_idx <= scan_idx + 1'b1;
      if (take_scan) begin
        best_found <= 1'b1;
        best_idx   <= scan_idx;
        best_time  <= entry_time[scan_idx];
        best_type  <= entry_type[scan_idx];
        best_ref   <= entry_ref[scan_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && pop_valid && out_free && !pop_cmd.is_rel) begin
      rsp.accepted   <= free_any;
      rsp.released   <= 1'b0;
      rsp.out_type   <= '0;
      rsp.out_handle <= '0;
      rsp.out_time   <= '0;
      rsp.occupancy  <= OCC_W'(free_any ? count + 1'b1 : count);
    end else if ((state == ST_FINISH) && out_free) begin
      rsp.accepted   <= 1'b0;
      rsp.released   <= ripe;
      rsp.out_type   <= ripe ? best_type : '0;
      rsp.out_handle <= ripe ? best_ref : '0;
      rsp.out_time   <= ripe ? best_time : '0;
      rsp.occupancy  <= OCC_W'(do_release ? count - 1'b1 : count);
    end
  end

endmodule

### tb/sv/tb_top.sv
module tb_top;
  import trpq_pkg::*;

  typedef struct {
    bit              acc;
    bit              rel;
    bit [TYPE_W-1:0] tag;
    bit [REF_W-1:0]  handle;
    bit [TIME_W-1:0] stamp;
    bit [OCC_W-1:0]  occ;
  } outcome_t;

  localparam bit [63:0] NEVER    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam bit [62:0] TIME_MAX = {TIME_W{1'b1}};

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  trpq_req_if req ();
  trpq_rsp_if rsp ();

  timed_release_priority_queue_core uut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  bit [TIME_W-1:0] slot_stamp [QUEUE_DEPTH];
  bit [TYPE_W-1:0] slot_tag [QUEUE_DEPTH];
  bit [REF_W-1:0]  slot_handle [QUEUE_DEPTH];
  bit              slot_live [QUEUE_DEPTH];
  bit [63:0]       oldest_stamp;
  bit [DELAY_W-1:0] hold_delay;
  int              held;

  outcome_t awaited_outcomes[$];
  int  mismatches;
  int  beats_sent, beats_checked, releases_seen, rejects_seen;
  bit  calm;
  bit [63:0] clock_base;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int earliest_slot();
    int best;
    best = -1;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (slot_live[i]) begin
        if (best < 0 || slot_stamp[i] < slot_stamp[best] ||
            (slot_stamp[i] == slot_stamp[best] && slot_handle[i] < slot_handle[best]))
          best = i;
      end
    end
    return best;
  endfunction

  function automatic outcome_t queue_step(bit kind, bit [TIME_W-1:0] ev_time,
                                          bit [TYPE_W-1:0] ev_type,
                                          bit [REF_W-1:0] ev_handle,
                                          bit [TIME_W-1:0] now);
    outcome_t o;
    int m;
    o = '{default: 0};
    if (kind == KIND_ADD) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (!slot_live[i]) begin
          slot_live[i] = 1'b1;
          slot_stamp[i] = ev_time;
          slot_tag[i] = ev_type;
          slot_handle[i] = ev_handle;
          held++;
          if ({1'b0, ev_time} < oldest_stamp) oldest_stamp = {1'b0, ev_time};
          o.acc = 1'b1;
          break;
        end
      end
    end else if (oldest_stamp != NEVER && oldest_stamp + hold_delay <= {1'b0, now}) begin
      m = earliest_slot();
      if (m >= 0 && {1'b0, slot_stamp[m]} + hold_delay <= {1'b0, now}) begin
        o.rel = 1'b1;
        o.tag = slot_tag[m];
        o.handle = slot_handle[m];
        o.stamp = slot_stamp[m];
        slot_live[m] = 1'b0;
        held--;
        m = earliest_slot();
        oldest_stamp = (m >= 0) ? {1'b0, slot_stamp[m]} : NEVER;
      end
    end
    o.occ = held[OCC_W-1:0];
    return o;
  endfunction

  // called at a falling edge; returns at a falling edge with valid still high
  task automatic send_beat(bit kind, bit [TIME_W-1:0] ev_time, bit [TYPE_W-1:0] ev_type,
                           bit [REF_W-1:0] ev_handle, bit [TIME_W-1:0] now);
    if (!calm) begin
      while ($urandom_range(0, 99) < 24) begin
        req.valid = 1'b0;
        @(negedge clk);
      end
    end
    req.valid = 1'b1;
    req.kind = kind;
    req.event_time = ev_time;
    req.event_type = ev_type;
    req.event_handle = ev_handle;
    req.now_time = now;
    do @(posedge clk); while (!req.ready);
    awaited_outcomes.push_back(queue_step(kind, ev_time, ev_type, ev_handle, now));
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    req.valid = 1'b0;
    while (awaited_outcomes.size() != 0) @(negedge clk);
    repeat (QUEUE_DEPTH + 8) @(negedge clk);
  endtask

  task automatic write_delay(bit [DELAY_W-1:0] value);
    wait_idle();
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = ADDR_W'(4 * int'(REG_RELEASE_DELAY));
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    hold_delay = value;
  endtask

  function automatic bit [TIME_W-1:0] due_time(int offset);
    bit [63:0] n;
    n = clock_base + hold_delay;
    if (offset < 0 && n < 64'(-offset)) n = 0;
    else n = n + 64'(signed'(offset));
    return n[63] ? TIME_MAX : n[TIME_W-1:0];
  endfunction

  task automatic test_extremes();
    write_delay(0);
    send_beat(KIND_RELEASE, '1, '1, '1, 0);
    send_beat(KIND_ADD, TIME_MAX, '1, '1, '1);
    send_beat(KIND_ADD, 0, 0, 0, 0);
    send_beat(KIND_RELEASE, 0, 0, 0, 0);
    send_beat(KIND_RELEASE, '1, '1, '1, TIME_MAX - 1);
    send_beat(KIND_RELEASE, 0, 0, 0, TIME_MAX);
  endtask

  task automatic test_full_store();
    for (int i = 0; i <= QUEUE_DEPTH; i++)
      send_beat(KIND_ADD, 5, $urandom, REF_W'(i % 4), 0);
    for (int i = 0; i < 6; i++)
      send_beat(KIND_RELEASE, 0, 0, 0, 5);
  endtask

  task automatic test_delay_edges();
    write_delay('1);
    send_beat(KIND_ADD, 0, 32'h5A5A_A5A5, 16'h1234, 0);
    send_beat(KIND_RELEASE, 0, 0, 0, 63'h0_FFFF_FFFE);
    send_beat(KIND_RELEASE, 0, 0, 0, 63'h0_FFFF_FFFF);
  endtask

  task automatic test_random_traffic(bit [DELAY_W-1:0] delay, int count);
    bit kind;
    bit [TIME_W-1:0] ev_time, now;
    bit [REF_W-1:0] h;
    write_delay(delay);
    for (int i = 0; i < count; i++) begin
      kind = ($urandom_range(0, 99) < 55) ? KIND_ADD : KIND_RELEASE;
      if ($urandom_range(0, 9) == 0) ev_time = TIME_W'({$urandom, $urandom});
      else ev_time = clock_base[TIME_W-1:0] + $urandom_range(0, 200);
      h = ($urandom_range(0, 1) == 0) ? REF_W'($urandom_range(0, 7)) : REF_W'($urandom);
      if ($urandom_range(0, 99) < 15) now = TIME_W'({$urandom, $urandom});
      else now = due_time(int'($urandom_range(0, 250)) - 100);
      send_beat(kind, ev_time, $urandom, h, now);
      clock_base += $urandom_range(0, 20);
    end
  endtask

  always @(negedge clk) begin
    rsp.ready = calm || rst || ($urandom_range(0, 99) >= 24);
  end

  always @(posedge clk) begin
    outcome_t exp_o;
    if (!rst && rsp.valid && rsp.ready) begin
      if (awaited_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
      end else begin
        exp_o = awaited_outcomes.pop_front();
        beats_checked++;
        if (exp_o.rel) releases_seen++;
        if (!exp_o.acc && !exp_o.rel) rejects_seen++;
        if (rsp.accepted !== exp_o.acc || rsp.released !== exp_o.rel ||
            rsp.out_type !== exp_o.tag || rsp.out_handle !== exp_o.handle ||
            rsp.out_time !== exp_o.stamp || rsp.occupancy !== exp_o.occ) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("mismatch beat %0d: exp acc=%0b rel=%0b type=%h ref=%h time=%h occ=%0d",
                   beats_checked, exp_o.acc, exp_o.rel, exp_o.tag, exp_o.handle,
                   exp_o.stamp, exp_o.occ);
            $display(", got acc=%0b rel=%0b type=%h ref=%h time=%h occ=%0d",
                     rsp.accepted, rsp.released, rsp.out_type,
                     rsp.out_handle, rsp.out_time, rsp.occupancy);
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    calm = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req.valid = 1'b0;
    req.kind = KIND_ADD;
    req.event_time = '0;
    req.event_type = '0;
    req.event_handle = '0;
    req.now_time = '0;
    rsp.ready = 1'b1;
    for (int i = 0; i < QUEUE_DEPTH; i++) slot_live[i] = 1'b0;
    oldest_stamp = NEVER;
    hold_delay = '0;
    held = 0;
    clock_base = {22'd0, 10'($urandom_range(0, 1023)), $urandom};
    repeat (6) @(negedge clk);
    rst = 1'b0;
    test_extremes();
    test_full_store();
    test_delay_edges();
    test_random_traffic(0, 220);
    test_random_traffic('1, 220);
    calm = 1'b1;
    test_random_traffic(1, 220);
    calm = 1'b0;
    test_random_traffic(37, 220);
    test_random_traffic($urandom, 220);
    wait_idle();
    $display("sent %0d beats, checked %0d results: %0d releases, %0d empty or rejected",
             beats_sent, beats_checked, releases_seen, rejects_seen);
    $display("release delays 0, 1, 37, random and all ones, with random stalls");
    if (mismatches == 0 && awaited_outcomes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
